// File: rtl/bxavg_pkg.sv
// Shared widths, register indexes and controller/datapath interface types for the box downsampler.
package bxavg_pkg;

    localparam int PIXEL_W     = 8;
    localparam int AVG_W       = 8;
    localparam int FACTOR_W    = 5;
    localparam int COLS_W      = 11;
    localparam int ROWS_W      = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    // Default size limits handed to the top level parameters
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_MAX_FACTOR = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS   = 2'd2;

    // Register values after reset
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd2;
    localparam logic [COLS_W-1:0]   COLS_RST   = 11'd1024;
    localparam logic [ROWS_W-1:0]   ROWS_RST   = 11'd1024;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_pixel;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic block_done;
        logic strip_last;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/bxavg_datapath.sv
// Datapath: frame counters, column sum store, restoring divider and output register.
module bxavg_datapath
    import bxavg_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [PIXEL_W-1:0]     pixel,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [AVG_W-1:0]       average,
    output logic                   row_end,
    output logic                   frame_end
);

    localparam int PIX_MAX = (1 << PIXEL_W) - 1;
    localparam int COL_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int FAC_W   = $clog2(MAX_FACTOR + 1);
    localparam int PH_W    = $clog2(MAX_FACTOR);
    localparam int ADDR_W  = $clog2(MAX_COLS);
    localparam int RS_W    = $clog2(MAX_FACTOR * PIX_MAX + 1);
    localparam int SUM_W   = $clog2(MAX_FACTOR * MAX_FACTOR * PIX_MAX + 1);
    localparam int DIV_W   = SUM_W + 2;
    localparam int D_W     = 2 * FAC_W;
    localparam int STEP_W  = $clog2(AVG_W);

    // Configuration registers
    logic [FACTOR_W-1:0] factor_reg;
    logic [COLS_W-1:0]   cols_reg;
    logic [ROWS_W-1:0]   rows_reg;
    logic                cfg_hit;

    // Frame position state
    logic [COL_W-1:0]  colpos_reg, colpos_next;
    logic [ROW_W-1:0]  rowpos_reg, rowpos_next;
    logic [PH_W-1:0]   hphase_reg, hphase_next;
    logic [PH_W-1:0]   vphase_reg, vphase_next;
    logic [RS_W-1:0]   rsum_reg, rsum_next;
    logic [ADDR_W-1:0] oc_reg, oc_next;

    // Per-block payload captured when a block row completes
    logic [RS_W-1:0]   blk_sum_reg;
    logic [ADDR_W-1:0] oc_hold_reg;
    logic              first_sub_reg;
    logic              re_pend_reg;
    logic              fe_pend_reg;
    logic [SUM_W-1:0]  rd_data_reg;

    // Column sum store
    logic [SUM_W-1:0] col_mem [MAX_COLS];
    logic [SUM_W-1:0] acc_sum;

    // Divider
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsh_reg;
    logic [AVG_W-1:0]  quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic [D_W-1:0]    d_val;
    logic              rem_ge;

    // Output register
    logic             out_valid_reg;
    logic [AVG_W-1:0] avg_reg;
    logic             re_reg;
    logic             fe_reg;

    // Clamped sizes and position decodes
    logic [FAC_W-1:0] cf;
    logic [COL_W-1:0] nc;
    logic [ROW_W-1:0] nr;
    logic [COL_W-1:0] col_left;
    logic [ROW_W-1:0] row_left;
    logic             col_active;
    logic             row_active;
    logic             hph_last;
    logic             vph_last;
    logic             col_end;
    logic             last_row;
    logic             block_done;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RST;
            cols_reg   <= COLS_RST;
            rows_reg   <= ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_COLS:   cols_reg   <= cfg_data[COLS_W-1:0];
                REG_ROWS:   rows_reg   <= cfg_data[ROWS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Decode a write that restarts the frame
    always_comb
    begin
        unique case (cfg_index)
            REG_FACTOR, REG_COLS, REG_ROWS: cfg_hit = cfg_we;
            default:                        cfg_hit = 1'b0;
        endcase
    end

    // Clamp sizes into their usable ranges
    always_comb
    begin
        if (factor_reg == '0)
            cf = FAC_W'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            cf = FAC_W'(MAX_FACTOR);
        else
            cf = FAC_W'(factor_reg);

        if (cols_reg == '0)
            nc = COL_W'(1);
        else if (32'(cols_reg) > MAX_COLS)
            nc = COL_W'(MAX_COLS);
        else
            nc = COL_W'(cols_reg);

        if (rows_reg == '0)
            nr = ROW_W'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            nr = ROW_W'(MAX_ROWS);
        else
            nr = ROW_W'(rows_reg);
    end

    // A block is whole when enough columns and rows remain at its start
    assign col_left   = nc - colpos_reg;
    assign row_left   = nr - rowpos_reg;
    assign col_active = (hphase_reg != '0) || (32'(col_left) >= 32'(cf));
    assign row_active = (vphase_reg != '0) || (32'(row_left) >= 32'(cf));
    assign hph_last   = (32'(hphase_reg) + 1) == 32'(cf);
    assign vph_last   = (32'(vphase_reg) + 1) == 32'(cf);
    assign col_end    = (32'(colpos_reg) + 1) == 32'(nc);
    assign last_row   = (32'(rowpos_reg) + 1) == 32'(nr);
    assign block_done = row_active && col_active && hph_last;

    // Advance positions, phases and the running row sum
    always_comb
    begin
        colpos_next = colpos_reg;
        rowpos_next = rowpos_reg;
        hphase_next = hphase_reg;
        vphase_next = vphase_reg;
        rsum_next   = rsum_reg;
        oc_next     = oc_reg;
        if (cfg_hit)
        begin
            colpos_next = '0;
            rowpos_next = '0;
            hphase_next = '0;
            vphase_next = '0;
            rsum_next   = '0;
            oc_next     = '0;
        end
        else if (cmd.take_pixel)
        begin
            if (row_active && col_active)
            begin
                if (hph_last)
                begin
                    rsum_next   = '0;
                    hphase_next = '0;
                    oc_next     = oc_reg + ADDR_W'(1);
                end
                else
                begin
                    rsum_next   = rsum_reg + RS_W'(pixel);
                    hphase_next = hphase_reg + PH_W'(1);
                end
            end
            if (col_end)
            begin
                colpos_next = '0;
                rsum_next   = '0;
                hphase_next = '0;
                oc_next     = '0;
                if (row_active)
                    vphase_next = vph_last ? '0 : vphase_reg + PH_W'(1);
                if (last_row)
                begin
                    rowpos_next = '0;
                    vphase_next = '0;
                end
                else
                begin
                    rowpos_next = rowpos_reg + ROW_W'(1);
                end
            end
            else
            begin
                colpos_next = colpos_reg + COL_W'(1);
            end
        end
    end

    // Hold frame position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colpos_reg <= '0;
            rowpos_reg <= '0;
            hphase_reg <= '0;
            vphase_reg <= '0;
            rsum_reg   <= '0;
            oc_reg     <= '0;
        end
        else
        begin
            colpos_reg <= colpos_next;
            rowpos_reg <= rowpos_next;
            hphase_reg <= hphase_next;
            vphase_reg <= vphase_next;
            rsum_reg   <= rsum_next;
            oc_reg     <= oc_next;
        end
    end

    // Capture the finished block row and its output flags
    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel && block_done)
        begin
            blk_sum_reg   <= rsum_reg + RS_W'(pixel);
            oc_hold_reg   <= oc_reg;
            first_sub_reg <= (vphase_reg == '0);
            re_pend_reg   <= (32'(col_left) <= 32'(cf));
            fe_pend_reg   <= (32'(col_left) <= 32'(cf)) && (32'(row_left) <= 32'(cf));
        end
    end

    // Fold the block row into the column sum; the first sub-row overwrites
    assign acc_sum = (first_sub_reg ? '0 : rd_data_reg) + SUM_W'(blk_sum_reg);

    // Column sum store: read on pixel accept, written back in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accumulate)
            col_mem[oc_hold_reg] <= acc_sum;
        if (cmd.take_pixel)
            rd_data_reg <= col_mem[oc_reg];
    end

    // Divide (2*sum + d) by 2*d, one quotient bit per cycle
    assign d_val  = D_W'(cf) * D_W'(cf);
    assign rem_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= DIV_W'({acc_sum, 1'b0}) + DIV_W'(d_val);
            dsh_reg  <= DIV_W'({d_val, 1'b0}) << (AVG_W - 1);
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[AVG_W-2:0], rem_ge};
        end
    end

    // Count divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.div_start)
            step_reg <= '0;
        else if (cmd.div_step)
            step_reg <= step_reg + STEP_W'(1);
    end

    // Output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            avg_reg <= quot_reg;
            re_reg  <= re_pend_reg;
            fe_reg  <= fe_pend_reg;
        end
    end

    assign status.block_done = block_done;
    assign status.strip_last = vph_last;
    assign status.div_last   = (step_reg == STEP_W'(AVG_W - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign average   = avg_reg;
    assign row_end   = re_reg;
    assign frame_end = fe_reg;

`ifndef ASSERT_OFF
    // A new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

    // Phases stay inside the block size
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(hphase_reg) < 32'(cf)) && (32'(vphase_reg) < 32'(cf)))
        else $error("block phase outside the factor");

    // Positions stay inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(colpos_reg) < 32'(nc)) && (32'(rowpos_reg) < 32'(nr)))
        else $error("pixel position outside the frame");
`endif

endmodule

// File: rtl/bxavg_ctrl.sv
// Controller: sequences pixel accept, column sum update, division and output load.
module bxavg_ctrl
    import bxavg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_ACC_PART = 5'b00010,
        ST_ACC_FULL = 5'b00100,
        ST_DIV      = 5'b01000,
        ST_HOLD     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_pixel = 1'b1;
                    if (status.block_done && status.strip_last)
                        state_next = ST_ACC_FULL;
                    else if (status.block_done)
                        state_next = ST_ACC_PART;
                end
            end
            ST_ACC_PART:
            begin
                cmd.accumulate = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_ACC_FULL:
            begin
                cmd.accumulate = 1'b1;
                cmd.div_start  = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    // A pixel that closes a block row stalls input for the update
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.block_done) |=> !in_ready)
        else $error("input taken during column sum update");
`endif

endmodule

// File: rtl/box_average_downsample.sv
// Top level of the box-average image downsampler.
//
//   channel   direction  handshake                       contents
//   s_axis    in         s_axis_tvalid / s_axis_tready   pixel
//   m_axis    out        m_axis_tvalid / m_axis_tready   average, row_end, frame_end
//   cfg       in         cfg_we                          factor, image_cols, image_rows
//
// A pixel that does not finish a block row is taken while input stays ready. A pixel
// that finishes a block row stalls input while the column sum store, read on accept,
// is written back the next cycle. A pixel that finishes a whole block also stalls
// input through the update, the bit-serial divider and a load into the output
// register, which waits while the output register stays full. The column sum store
// needs no clearing after reset; each strip writes an entry before reading it.
module box_average_downsample
    import bxavg_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,   // [7:0] pixel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [AVG_W-1:0]       m_axis_tdata,   // [7:0] average
    output logic                   m_axis_tlast,   // row_end
    output logic                   m_axis_tuser,   // [0] frame_end
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence control
    bxavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Counters, store, divider and output word
    bxavg_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .average   (m_axis_tdata),
        .row_end   (m_axis_tlast),
        .frame_end (m_axis_tuser)
    );

endmodule

// File: test/tb_box_average_downsample.sv
// Self-checking stream testbench for the box-average image downsampler.
module tb_box_average_downsample
    import bxavg_pkg::*;
();

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS = 700;

    typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_EDGES} fill_t;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic             row_end;
        logic             frame_end;
    } block_mean_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [AVG_W-1:0]       m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Stimulus and expected results
    logic [PIXEL_W-1:0] pixel_q[$];
    block_mean_t        expected_means[$];
    block_mean_t        got_mean;
    int                 error_count = 0;

    // Idle control shared between the stimulus and the two stream sides
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit rx_hold_req = 1'b0;
    int tx_gap = 0;
    int rx_stall = 0;

    // Predictor copy of the registers and the downsampler state
    logic [FACTOR_W-1:0] cur_factor = FACTOR_RST;
    logic [COLS_W-1:0]   cur_cols = COLS_RST;
    logic [ROWS_W-1:0]   cur_rows = ROWS_RST;
    logic [15:0]         strip_sums[DEF_MAX_COLS];
    logic [COLS_W-1:0]   col_pos = '0;
    logic [ROWS_W-1:0]   row_pos = '0;
    logic [4:0]          h_phase = '0;
    logic [4:0]          v_phase = '0;
    logic [15:0]         row_sum = '0;

    box_average_downsample uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Limit a register value to 1..hi
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
            $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Advance the predicted image walk by one pixel and queue any finished block mean
    task automatic downsample_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned cf, nc, nr, out_cols, used_cols, used_rows, oc, d;
        logic        row_active;
        block_mean_t m;
        cf = clamp_size(cur_factor, DEF_MAX_FACTOR);
        nc = clamp_size(cur_cols, DEF_MAX_COLS);
        nr = clamp_size(cur_rows, DEF_MAX_ROWS);
        out_cols = nc / cf;
        used_cols = out_cols * cf;
        used_rows = (nr / cf) * cf;
        row_active = (row_pos < used_rows);

        if (row_active && col_pos < used_cols)
        begin
            row_sum += px;
            h_phase++;
            if (h_phase >= cf)
            begin
                oc = col_pos / cf;
                if (oc >= DEF_MAX_COLS)
                    oc = DEF_MAX_COLS - 1;
                if (v_phase == 0)
                    strip_sums[oc] = row_sum;
                else
                    strip_sums[oc] += row_sum;
                row_sum = '0;
                h_phase = '0;
                if (v_phase + 1 >= cf)
                begin
                    d = cf * cf;
                    m.average = AVG_W'((2 * strip_sums[oc] + d) / (2 * d));
                    m.row_end = (oc + 1 == out_cols);
                    m.frame_end = m.row_end && (row_pos + 1 == used_rows);
                    expected_means.push_back(m);
                end
            end
        end

        // Wrap column, then row
        col_pos++;
        if (col_pos >= nc)
        begin
            col_pos = '0;
            row_sum = '0;
            h_phase = '0;
            if (row_active)
            begin
                v_phase++;
                if (v_phase >= cf)
                    v_phase = '0;
            end
            row_pos++;
            if (row_pos >= nr)
            begin
                row_pos = '0;
                v_phase = '0;
            end
        end
    endtask

    // Pixel source: hold each word until taken, insert gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            tx_gap = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                downsample_pixel(s_axis_tdata);
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pixel_q.pop_front();
                if (tx_idle_on)
                    tx_gap = pick_gap();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: check each taken word, stall at random or on a long hold request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word average=%0d last=%b user=%b",
                                              m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end
                else
                begin
                    got_mean = expected_means.pop_front();
                    if (m_axis_tdata !== got_mean.average)
                        report_mismatch($sformatf("average got %0d want %0d",
                                                  m_axis_tdata, got_mean.average));
                    if (m_axis_tlast !== got_mean.row_end)
                        report_mismatch($sformatf("row_end got %b want %b",
                                                  m_axis_tlast, got_mean.row_end));
                    if (m_axis_tuser !== got_mean.frame_end)
                        report_mismatch($sformatf("frame_end got %b want %b",
                                                  m_axis_tuser, got_mean.frame_end));
                end
            end

            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (rx_idle_on)
                    rx_stall = pick_gap();
            end
        end
    end

    // Write one register; the enable stays high until end_writes
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_FACTOR: cur_factor = val[FACTOR_W-1:0];
            REG_COLS:   cur_cols = val[COLS_W-1:0];
            REG_ROWS:   cur_rows = val[ROWS_W-1:0];
            default:    ;
        endcase
        // Any real register write restarts the frame walk
        if (idx != REG_UNUSED)
        begin
            col_pos = '0;
            row_pos = '0;
            h_phase = '0;
            v_phase = '0;
            row_sum = '0;
        end
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] f, input logic [CFG_DATA_W-1:0] c,
                            input logic [CFG_DATA_W-1:0] r);
        write_reg(REG_FACTOR, f);
        write_reg(REG_COLS, c);
        write_reg(REG_ROWS, r);
        end_writes();
    endtask

    task automatic push_pixels(input int n, input fill_t mode);
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                FILL_MAX:   pixel_q.push_back(8'hFF);
                FILL_ZERO:  pixel_q.push_back(8'h00);
                FILL_EDGES:
                    case ($urandom_range(0, 3))
                        0:       pixel_q.push_back(8'h00);
                        1:       pixel_q.push_back(8'hFF);
                        2:       pixel_q.push_back(8'h7F);
                        default: pixel_q.push_back(8'h80);
                    endcase
                default:    pixel_q.push_back(PIXEL_W'($urandom));
            endcase
        end
    endtask

    // Wait until every pixel is taken and every block mean has arrived, then settle
    task automatic drain();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || expected_means.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int    random_count;
        int    f_sel, eff_f, eff_c, eff_r, n;
        logic [CFG_DATA_W-1:0] f, c, r;
        fill_t mode;

        random_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: factor 2 over 1024 columns, so means start on the second row
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        push_pixels(DEF_MAX_COLS + 8, FILL_RANDOM);
        drain();

        // Factor 1 on a 2x2 image, then a paused second frame around an unused index write
        set_size(11'd1, 11'd2, 11'd2);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h80);
        pixel_q.push_back(8'h01);
        pixel_q.push_back(8'hAA);
        pixel_q.push_back(8'h55);
        drain();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        end_writes();
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        drain();

        // Factor 2 on 3x3: right column and bottom row dropped, block sum of 2 rounds up
        set_size(11'd2, 11'd3, 11'd3);
        pixel_q.push_back(8'd1);
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd7);
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd1);
        pixel_q.push_back(8'd9);
        pixel_q.push_back(8'd5);
        pixel_q.push_back(8'd5);
        pixel_q.push_back(8'd5);
        drain();

        // Zero factor and sizes act as one
        set_size(11'd0, 11'd0, 11'd0);
        pixel_q.push_back(8'd200);
        drain();

        // Factor larger than the image: consumed, nothing produced
        set_size(11'd5, 11'd4, 11'd4);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFF);
        drain();

        // Oversize columns clamp to the limit; factor bits above the field are dropped.
        // Hold the sink off for a long stretch while pixels keep coming.
        set_size(11'h7E0, 11'h7FF, 11'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        rx_hold_req = 1'b1;
        push_pixels(DEF_MAX_COLS, FILL_RANDOM);
        drain();

        // Oversize factor clamps to the limit; largest block of full-scale pixels
        set_size(11'h7F1, 11'd16, 11'd16);
        tx_idle_on = 1'b1;
        push_pixels(256, FILL_MAX);
        drain();

        // Random frames: mostly small factors and sizes
        while (random_count < RANDOM_ITEMS)
        begin
            f_sel = $urandom_range(0, 19);
            if (f_sel == 0)
                f = 11'd0;
            else if (f_sel == 1)
                f = CFG_DATA_W'($urandom_range(17, 31));
            else if (f_sel < 4)
                f = CFG_DATA_W'($urandom_range(5, 16));
            else
                f = CFG_DATA_W'($urandom_range(1, 4));
            eff_f = clamp_size(f[FACTOR_W-1:0], DEF_MAX_FACTOR);

            if (eff_f > 4)
            begin
                c = CFG_DATA_W'(eff_f + $urandom_range(0, 3));
                r = CFG_DATA_W'(eff_f + $urandom_range(0, 3));
            end
            else
            begin
                c = CFG_DATA_W'($urandom_range(0, 20));
                r = CFG_DATA_W'($urandom_range(0, 20));
            end
            if ($urandom_range(0, 9) == 0)
                r = CFG_DATA_W'($urandom_range(0, eff_f - 1));
            eff_c = clamp_size(c, DEF_MAX_COLS);
            eff_r = clamp_size(r, DEF_MAX_ROWS);

            set_size(f, c, r);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       mode = FILL_MAX;
                1:       mode = FILL_ZERO;
                2:       mode = FILL_EDGES;
                default: mode = FILL_RANDOM;
            endcase

            // Whole frames, sometimes followed by a partial one cut off by the next write
            n = $urandom_range(1, 2) * eff_c * eff_r;
            if (eff_c * eff_r > 1 && $urandom_range(0, 3) == 0)
                n += $urandom_range(1, eff_c * eff_r - 1);
            push_pixels(n, mode);
            random_count += n;
            drain();
        end

        if (error_count == 0)
            $display("PASS box_average_downsample");
        else
            $display("FAIL box_average_downsample");
        $finish;
    end

    // Overall time limit
    initial
    begin
        #15000000;
        $display("FAIL box_average_downsample");
        $finish;
    end

endmodule
